@@ rtl/core/cff_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_pkg
// Shared types and word layout constants for the compacting fetch FIFO.
// ----------------------------------------------------------------------------
package cff_pkg;

    // Input word layout, lowest bit first.
    localparam int IN_W          = 136;
    localparam int IN_PKT_VALID  = 0;
    localparam int IN_MASK_LO    = 1;
    localparam int IN_MASK_W     = 4;
    localparam int IN_SLOT_LO    = 5;
    localparam int SLOT_W        = 32;
    localparam int MAX_LANES     = 4;
    localparam int IN_POP_READY  = 133;
    localparam int IN_FLUSH      = 134;

    // Output word layout, lowest bit first.
    localparam int OUT_W         = 48;
    localparam int OUT_HEAD_VAL  = 0;
    localparam int OUT_HEAD_LO   = 1;
    localparam int HEAD_W        = 32;
    localparam int OUT_POP_DONE  = 33;
    localparam int OUT_PUSH_RDY  = 34;
    localparam int OUT_PUSH_DONE = 35;
    localparam int OUT_FILL_LO   = 36;
    localparam int FILL_W        = 5;
    localparam int OUT_FULL      = 41;
    localparam int OUT_EMPTY     = 42;
    localparam int OUT_USED      = 43;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WRITE,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic write_step;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic lane_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/cff_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/cff_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_ctrl
// Sequencer that walks one word through evaluate, lane write, commit, output.
// ----------------------------------------------------------------------------
module cff_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  cff_pkg::t_status  i_status,
    output cff_pkg::t_cmd     o_cmd
);

    cff_pkg::t_state r_state;
    cff_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cff_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cff_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = cff_pkg::S_EVAL;
                end
            end
            cff_pkg::S_EVAL: begin
                n_state = cff_pkg::S_WRITE;
            end
            cff_pkg::S_WRITE: begin
                if (i_status.lane_last) begin
                    n_state = cff_pkg::S_COMMIT;
                end
            end
            cff_pkg::S_COMMIT: begin
                n_state = cff_pkg::S_OUT;
            end
            cff_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = cff_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cff_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            cff_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            cff_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            cff_pkg::S_WRITE: begin
                o_cmd.write_step = 1'b1;
            end
            cff_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            cff_pkg::S_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/cff_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_dp
// Datapath: captured word, pointers, occupancy, ring RAM and output register.
// ----------------------------------------------------------------------------
module cff_dp #(
    parameter int DEPTH     = 16,
    parameter int LANES     = 4,
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cff_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [cff_pkg::OUT_W-1:0] o_m_tdata,
    input  cff_pkg::t_cmd             i_cmd,
    output cff_pkg::t_status          o_status
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int AV_W   = OCC_W + 1;
    localparam int SUM_W  = PTR_W + 3;
    localparam int CNT_W  = $clog2(LANES + 1);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    // Captured word.
    logic                 r_pkt_valid;
    logic [LANES-1:0]     r_mask;
    logic [WORD_BITS-1:0] r_slot [LANES];
    logic                 r_pop_ready;
    logic                 r_flush;

    // Evaluated step.
    logic [CNT_W-1:0]     r_incoming;
    logic                 r_had;
    logic                 r_pop;
    logic                 r_push_rdy;
    logic                 r_push;
    logic [WORD_BITS-1:0] r_head_word;

    // Lane write walk.
    logic [LANE_W-1:0]    r_lane;
    logic [CNT_W-1:0]     r_pos;

    // Ring state.
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [OCC_W-1:0]     r_occ;

    // Output register.
    logic                     r_out_valid;
    logic [cff_pkg::OUT_W-1:0] r_out_data;

    logic [CNT_W-1:0]     n_incoming;
    logic                 n_pop;
    logic [AV_W-1:0]      n_avail;
    logic                 n_push_rdy;
    logic [SUM_W-1:0]     wr_sum;
    logic [PTR_W-1:0]     wr_addr;
    logic                 wr_en;
    logic [SUM_W-1:0]     tail_sum;
    logic [PTR_W-1:0]     n_tail_adv;
    logic [PTR_W-1:0]     n_head_adv;
    logic [OCC_W-1:0]     n_occ;
    logic [WORD_BITS-1:0] rd_data;
    logic [cff_pkg::OUT_W-1:0] n_out_data;

    // Evaluate the step from the captured word and the current ring state.
    always_comb begin
        n_incoming = '0;
        for (int i = 0; i < LANES; i++) begin
            n_incoming = n_incoming + CNT_W'(r_mask[i]);
        end
        if (!r_pkt_valid) begin
            n_incoming = '0;
        end
        n_pop      = (r_occ != '0) && r_pop_ready && !r_flush;
        n_avail    = AV_W'(DEPTH) - AV_W'(r_occ) + AV_W'(n_pop);
        n_push_rdy = !r_flush && (AV_W'(n_incoming) <= n_avail);
    end

    // Packed lanes land at consecutive slots from the tail.
    always_comb begin
        wr_sum  = SUM_W'(r_tail) + SUM_W'(r_pos);
        wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                            : PTR_W'(wr_sum);
        wr_en   = i_cmd.write_step && r_push && r_mask[r_lane];

        tail_sum   = SUM_W'(r_tail) + SUM_W'(r_incoming);
        n_tail_adv = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
        n_head_adv = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        n_occ      = r_occ - OCC_W'(r_pop) + (r_push ? OCC_W'(r_incoming) : '0);
    end

    // Output word assembled from the evaluated step and the committed state.
    always_comb begin
        n_out_data = '0;
        n_out_data[cff_pkg::OUT_HEAD_VAL] = r_had && !r_flush;
        n_out_data[cff_pkg::OUT_HEAD_LO +: cff_pkg::HEAD_W] =
            cff_pkg::HEAD_W'(r_head_word);
        n_out_data[cff_pkg::OUT_POP_DONE]  = r_pop;
        n_out_data[cff_pkg::OUT_PUSH_RDY]  = r_push_rdy;
        n_out_data[cff_pkg::OUT_PUSH_DONE] = r_push;
        n_out_data[cff_pkg::OUT_FILL_LO +: cff_pkg::FILL_W] =
            cff_pkg::FILL_W'(r_occ);
        n_out_data[cff_pkg::OUT_FULL]  = (r_occ == OCC_W'(DEPTH));
        n_out_data[cff_pkg::OUT_EMPTY] = (r_occ == '0);
    end

    cff_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_slot[r_lane]),
        .i_re    (i_cmd.capture),
        .i_raddr (r_head),
        .o_rdata (rd_data)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pkt_valid <= i_s_tdata[cff_pkg::IN_PKT_VALID];
            r_mask      <= i_s_tdata[cff_pkg::IN_MASK_LO +: LANES];
            r_pop_ready <= i_s_tdata[cff_pkg::IN_POP_READY];
            r_flush     <= i_s_tdata[cff_pkg::IN_FLUSH];
            for (int i = 0; i < LANES; i++) begin
                r_slot[i] <= WORD_BITS'(
                    i_s_tdata[cff_pkg::IN_SLOT_LO + i*cff_pkg::SLOT_W +: cff_pkg::SLOT_W]);
            end
        end
        if (i_cmd.eval) begin
            r_incoming  <= n_incoming;
            r_had       <= (r_occ != '0);
            r_pop       <= n_pop;
            r_push_rdy  <= n_push_rdy;
            r_push      <= r_pkt_valid && n_push_rdy;
            r_head_word <= (r_occ != '0) ? rd_data : '0;
            r_lane      <= '0;
            r_pos       <= '0;
        end
        if (i_cmd.write_step) begin
            r_lane <= r_lane + LANE_W'(1);
            if (r_mask[r_lane]) begin
                r_pos <= r_pos + CNT_W'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    // Ring pointers, occupancy and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_flush) begin
                    r_head <= '0;
                    r_tail <= '0;
                    r_occ  <= '0;
                end else begin
                    if (r_pop) begin
                        r_head <= n_head_adv;
                    end
                    if (r_push) begin
                        r_tail <= n_tail_adv;
                    end
                    r_occ <= n_occ;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.lane_last = (r_lane == LANE_W'(LANES - 1));
    assign o_status.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_data;

endmodule

@@ rtl/core/compacting_fetch_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_fetch_fifo
// Ring buffer of instruction words with a compacting multi-lane write side.
// ----------------------------------------------------------------------------
// Each input word on the slave stream describes one step of the fetch buffer:
// a packet of up to LANES instruction slots with a lane mask, the consumer's
// ready flag for the head entry, and a flush request. For every input word the
// block returns exactly one output word on the master stream, carrying the
// head entry seen before the step, the pop and push outcomes, and the fill
// level, full and empty flags after the step.
// An accepted packet is taken whole or not at all: its valid lanes must fit
// the free space, counting the slot freed by this step's pop. Taken lanes are
// packed in lane order at the tail. A flush empties the buffer and blocks
// both the push and the pop of that step.
// One word passes from acceptance to output through these steps: accepting it
// and starting the head read from the ring RAM, evaluating, one write per lane
// (the RAM has a single write port), committing the pointers and loading the
// output register once it is free. A new word is accepted once the previous
// one has reached the output register, so a stalled receiver holds back at
// most one finished word before input stalls.
// Reset clears the pointers, the fill level and the output valid; the ring
// contents are not cleared, and a stale entry is never returned as the head.
// ----------------------------------------------------------------------------
module compacting_fetch_fifo #(
    parameter int DEPTH     = 16,
    parameter int LANES     = 4,
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input word, lowest bit first: packet_valid[0], lane_mask[4:1],
    // slot_zero[36:5], slot_one[68:37], slot_two[100:69],
    // slot_three[132:101], pop_ready[133], flush_now[134], zero pad[135].
    input  logic [cff_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // Output word, lowest bit first: head_valid[0], head_word[32:1],
    // pop_done[33], push_ready[34], push_done[35], fill_level[40:36],
    // is_full[41], is_empty[42], zero pad[47:43].
    output logic [cff_pkg::OUT_W-1:0] o_m_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready
);

    cff_pkg::t_cmd    cmd;
    cff_pkg::t_status status;

    cff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cff_dp #(
        .DEPTH     (DEPTH),
        .LANES     (LANES),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule
